// ===== design/prs_pkg.sv =====
package prs_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CountWidth-1:0] CountMax = 8'hFF;

   localparam logic [CountWidth-1:0] PrechargeLimitReset = 8'd100;
   localparam logic [CountWidth-1:0] MessagePeriodReset = 8'h02;
   localparam logic [CountWidth-1:0] MonitorDelayReset = 8'd50;

   localparam logic [CsrIndexWidth-1:0] CsrPrechargeTicksLimit = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrMessagePeriod = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrMonitorDelay = 2'd2;

   typedef struct packed {
      logic [CountWidth-1:0] precharge_ticks_limit;
      logic [CountWidth-1:0] message_period;
      logic [CountWidth-1:0] monitor_delay;
   } prs_config_type;

   typedef struct packed {
      logic tick;
      logic air_closed;
      logic pack_connected;
      logic monitor_ok;
   } prs_request_type;

   typedef struct packed {
      logic precharge_drive;
      logic air_plus_drive;
      logic message_valid;
      logic msg_precharge_done;
      logic msg_pack_connected;
      logic msg_monitor_ok;
   } prs_result_type;

   // Saturating increment: hold at the top instead of wrapping.
   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] value);
      logic [CountWidth-1:0] result;
      if (value == CountMax) begin
         result = value;
      end else begin
         result = value + 1'b1;
      end
      return result;
   endfunction

endpackage

// ===== design/prs_core.sv =====
module prs_core
   import prs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  prs_request_type request,
   input  prs_config_type  config_regs,
   output prs_result_type  result
);

   logic [CountWidth-1:0] precharge_count_ff, precharge_count_in;
   logic [CountWidth-1:0] period_count_ff, period_count_in;
   logic [CountWidth-1:0] delay_count_ff, delay_count_in;
   logic                  precharge_done_ff, precharge_done_in;
   logic                  send_pending_ff, send_pending_in;
   logic                  delay_over_ff, delay_over_in;

   logic [CountWidth-1:0] precharge_count_tk;
   logic [CountWidth-1:0] period_count_tk;
   logic                  period_hit;
   logic                  precharge_done_tk;
   logic                  send_pending_tk;

   always_comb begin
      // Tick phase: advance counters, compare against limits.
      precharge_count_tk = request.tick ? sat_inc(precharge_count_ff) : precharge_count_ff;
      period_count_tk = request.tick ? sat_inc(period_count_ff) : period_count_ff;
      delay_count_in = request.tick ? sat_inc(delay_count_ff) : delay_count_ff;

      period_hit = request.tick && (period_count_tk > config_regs.message_period);
      send_pending_tk = send_pending_ff || period_hit;
      period_count_in = period_hit ? '0 : period_count_tk;
      delay_over_in = delay_over_ff ||
                      (request.tick && (delay_count_in > config_regs.monitor_delay));
      precharge_done_tk = precharge_done_ff ||
                          (request.tick &&
                           (precharge_count_tk > config_regs.precharge_ticks_limit));

      // Relay phase.
      result.precharge_drive = request.air_closed && !precharge_done_tk;
      result.air_plus_drive = request.air_closed && precharge_done_tk;
      precharge_count_in = request.air_closed ? precharge_count_tk : '0;
      precharge_done_in = request.air_closed && precharge_done_tk;

      // Message phase.
      result.message_valid = send_pending_tk && delay_over_in;
      send_pending_in = send_pending_tk && !result.message_valid;
      result.msg_precharge_done = result.message_valid && precharge_done_in;
      result.msg_pack_connected = result.message_valid && request.pack_connected;
      result.msg_monitor_ok = result.message_valid && request.monitor_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         precharge_count_ff <= '0;
         period_count_ff <= '0;
         delay_count_ff <= '0;
         precharge_done_ff <= 1'b0;
         send_pending_ff <= 1'b0;
         delay_over_ff <= 1'b0;
      end else if (step_en) begin
         precharge_count_ff <= precharge_count_in;
         period_count_ff <= period_count_in;
         delay_count_ff <= delay_count_in;
         precharge_done_ff <= precharge_done_in;
         send_pending_ff <= send_pending_in;
         delay_over_ff <= delay_over_in;
      end
   end

endmodule

// ===== design/precharge_relay_sequencer_unit.sv =====
// Precharge relay sequencer.
//
// Request channel (req_valid/req_ready): one request per sampling point, carrying
// an optional timer tick and the sensed pin levels (main relay sense, pack
// connector sense, insulation monitor status).
// Response channel (rsp_valid/rsp_ready): exactly one response per request, with
// the two relay drives and, when rsp_message_valid is high, the status message bits.
// Configuration port (csr_write_enable/csr_index/csr_wdata): writes the precharge
// limit, message period and monitor delay; write only while no request is in flight.
//
// Response: registered; it appears in the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_ready is high. The sequencer state
// and the response register update in the same cycle as the accept, so the only
// loop is the state update.
// Stall: while a response waits with rsp_ready low, req_ready drops; when the
// response is taken, a new request is accepted in that same cycle.
// Reset: counters and flags clear, the registers load their default limits
// (100, 2, 50) and the response register empties.
module precharge_relay_sequencer_unit
   import prs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_tick,
   input  logic                     req_air_closed,
   input  logic                     req_pack_connected,
   input  logic                     req_monitor_ok,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_precharge_drive,
   output logic                     rsp_air_plus_drive,
   output logic                     rsp_message_valid,
   output logic                     rsp_msg_precharge_done,
   output logic                     rsp_msg_pack_connected,
   output logic                     rsp_msg_monitor_ok,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CountWidth-1:0]    csr_wdata
);

   prs_config_type  config_ff;
   prs_request_type request;
   prs_result_type  result;
   prs_result_type  rsp_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;

   // Configuration registers; an unused index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         config_ff.precharge_ticks_limit <= PrechargeLimitReset;
         config_ff.message_period <= MessagePeriodReset;
         config_ff.monitor_delay <= MonitorDelayReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrPrechargeTicksLimit: config_ff.precharge_ticks_limit <= csr_wdata;
            CsrMessagePeriod:       config_ff.message_period <= csr_wdata;
            CsrMonitorDelay:        config_ff.monitor_delay <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accept whenever the response register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign request.tick = req_tick;
   assign request.air_closed = req_air_closed;
   assign request.pack_connected = req_pack_connected;
   assign request.monitor_ok = req_monitor_ok;

   prs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_accept),
      .request     (request),
      .config_regs (config_ff),
      .result      (result)
   );

   // Response register: hold while stalled, load on accept.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_precharge_drive = rsp_data_ff.precharge_drive;
   assign rsp_air_plus_drive = rsp_data_ff.air_plus_drive;
   assign rsp_message_valid = rsp_data_ff.message_valid;
   assign rsp_msg_precharge_done = rsp_data_ff.msg_precharge_done;
   assign rsp_msg_pack_connected = rsp_data_ff.msg_pack_connected;
   assign rsp_msg_monitor_ok = rsp_data_ff.msg_monitor_ok;

   // Never drive both relays at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_precharge_drive && rsp_air_plus_drive))
      else $error("both relay drives on");

   // Message bits stay low when no message goes out.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_message_valid) |->
         !(rsp_msg_precharge_done || rsp_msg_pack_connected || rsp_msg_monitor_ok))
      else $error("message bits set without a message");

   // An accepted request shows up as a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   // An open relay sense drops both drives.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_air_closed) |=>
         (!rsp_precharge_drive && !rsp_air_plus_drive))
      else $error("relay drive on with open sense");

endmodule
